// ===== sv/i2cmra_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cmra_pkg
// shared types and constants of the i2c register access master
// ----------------------------------------------------------------------------
package i2cmra_pkg;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // request kinds
    localparam logic [1:0] KIND_TICK  = 2'd0;
    localparam logic [1:0] KIND_WRITE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    // configuration register indexes
    localparam logic REG_DEV_WR_ADDR = 1'b0;
    localparam logic REG_DEV_RD_ADDR = 1'b1;

    // byte sequence positions
    localparam logic [1:0] BYTE_DEV_WR = 2'd0;
    localparam logic [1:0] BYTE_REG    = 2'd1;
    localparam logic [1:0] BYTE_DATA   = 2'd2;
    localparam logic [1:0] BYTE_DEV_RD = 2'd3;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] register_address;
        logic [7:0] write_value;
        logic       sda_sample;
    } in_item_t;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_released;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_value;
    } out_item_t;

endpackage

// ===== sv/i2cmra_if.sv =====
// ----------------------------------------------------------------------------
// i2cmra channel interfaces
// valid/ready channels carrying tick items and pin results
// ----------------------------------------------------------------------------
interface i2cmra_in_if;
    import i2cmra_pkg::*;

    logic     valid;
    logic     ready;
    in_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface i2cmra_out_if;
    import i2cmra_pkg::*;

    logic      valid;
    logic      ready;
    out_item_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/i2c_master_register_access_unit.sv =====
// ----------------------------------------------------------------------------
// i2c_master_register_access_unit
// datapath: request, input register, sequencer step, output register, response
// throughput: one tick per cycle unless stalled; in/out registers decouple stalls
// the bit sequencer advances one step per tick between the two registers
// reset: async active low; idle, scl and sda high and driven, read byte zero
// ----------------------------------------------------------------------------
module i2c_master_register_access_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    i2cmra_in_if.sink                     request,
    i2cmra_out_if.source                  response,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [i2cmra_pkg::APB_AW-1:0] paddr,
    input  logic [i2cmra_pkg::APB_DW-1:0] pwdata,
    output logic [i2cmra_pkg::APB_DW-1:0] prdata,
    output logic                          pready
);
    import i2cmra_pkg::*;

    typedef enum logic [4:0] {
        PH_IDLE, PH_ST0, PH_ST1, PH_ST2,
        PH_WB0, PH_WB1, PH_WB2,
        PH_AK0, PH_AK1, PH_AK2, PH_AK3, PH_AK4,
        PH_RD0, PH_RD1, PH_RB0, PH_RB1,
        PH_RN0, PH_RN1, PH_RN2,
        PH_SP0, PH_SP1, PH_SP2, PH_SP3
    } phase_t;

    logic [7:0] dev_wr_addr_reg;
    logic [7:0] dev_rd_addr_reg;

    logic       in_vld_reg;
    in_item_t   in_data_reg;
    logic       out_vld_reg;
    out_item_t  out_data_reg;
    out_item_t  out_data_next;

    phase_t     phase_reg, phase_next;
    logic [3:0] bit_count_reg, bit_count_next;
    logic [7:0] shift_byte_reg, shift_byte_next;
    logic [1:0] pending_kind_reg, pending_kind_next;
    logic [7:0] held_register_reg, held_register_next;
    logic [7:0] held_value_reg, held_value_next;
    logic [7:0] read_shift_reg, read_shift_next;
    logic [1:0] byte_index_reg, byte_index_next;
    logic       scl_reg, scl_next;
    logic       sda_reg, sda_next;
    logic       rel_reg, rel_next;
    logic       nack_reg, nack_next;
    logic       retry_reg, retry_next;
    logic [7:0] last_read_reg, last_read_next;
    logic       done_next;

    logic       move;
    logic       cfg_write;

    assign move          = in_vld_reg && (!out_vld_reg || response.ready);
    assign request.ready = !in_vld_reg || move;
    assign response.valid = out_vld_reg;
    assign response.data  = out_data_reg;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_DEV_RD_ADDR) ? {{(APB_DW-8){1'b0}}, dev_rd_addr_reg}
                                                     : {{(APB_DW-8){1'b0}}, dev_wr_addr_reg};

    // one sequencer step for the tick in the input register
    always_comb
    begin
        logic [3:0] bc_inc;
        bc_inc             = bit_count_reg + 4'd1;
        phase_next         = phase_reg;
        bit_count_next     = bit_count_reg;
        shift_byte_next    = shift_byte_reg;
        pending_kind_next  = pending_kind_reg;
        held_register_next = held_register_reg;
        held_value_next    = held_value_reg;
        read_shift_next    = read_shift_reg;
        byte_index_next    = byte_index_reg;
        scl_next           = scl_reg;
        sda_next           = sda_reg;
        rel_next           = rel_reg;
        nack_next          = nack_reg;
        retry_next         = retry_reg;
        last_read_next     = last_read_reg;
        done_next          = 1'b0;

        case (phase_reg)
            PH_IDLE:
            begin
                if (in_data_reg.kind == KIND_WRITE || in_data_reg.kind == KIND_READ)
                begin
                    pending_kind_next  = in_data_reg.kind;
                    held_register_next = in_data_reg.register_address;
                    held_value_next    = in_data_reg.write_value;
                    byte_index_next    = BYTE_DEV_WR;
                    bit_count_next     = 4'd0;
                    retry_next         = 1'b0;
                    nack_next          = 1'b0;
                    sda_next           = 1'b1;
                    phase_next         = PH_ST1;
                end
            end
            PH_ST0:
            begin
                sda_next   = 1'b1;
                phase_next = PH_ST1;
            end
            PH_ST1:
            begin
                scl_next   = 1'b1;
                phase_next = PH_ST2;
            end
            PH_ST2:
            begin
                sda_next        = 1'b0;
                shift_byte_next = (byte_index_reg == BYTE_DEV_WR) ? dev_wr_addr_reg
                                                                  : dev_rd_addr_reg;
                bit_count_next  = 4'd0;
                phase_next      = PH_WB0;
            end
            PH_WB0:
            begin
                scl_next   = 1'b0;
                phase_next = PH_WB1;
            end
            PH_WB1:
            begin
                sda_next   = shift_byte_reg[7];
                phase_next = PH_WB2;
            end
            PH_WB2:
            begin
                scl_next        = 1'b1;
                shift_byte_next = {shift_byte_reg[6:0], 1'b0};
                bit_count_next  = bc_inc;
                phase_next      = (bc_inc >= BITS_PER_BYTE) ? PH_AK0 : PH_WB0;
            end
            PH_AK0:
            begin
                scl_next   = 1'b0;
                phase_next = PH_AK1;
            end
            PH_AK1:
            begin
                rel_next   = 1'b1;
                phase_next = PH_AK2;
            end
            PH_AK2:
            begin
                scl_next   = 1'b1;
                phase_next = PH_AK3;
            end
            PH_AK3:
            begin
                nack_next  = in_data_reg.sda_sample;
                scl_next   = 1'b0;
                phase_next = PH_AK4;
            end
            PH_AK4:
            begin
                rel_next = 1'b0;
                if (nack_reg)
                begin
                    retry_next = 1'b1;
                    phase_next = PH_SP0;
                end
                else
                begin
                    case (byte_index_reg)
                        BYTE_DEV_WR:
                        begin
                            shift_byte_next = held_register_reg;
                            bit_count_next  = 4'd0;
                            byte_index_next = BYTE_REG;
                            phase_next      = PH_WB0;
                        end
                        BYTE_REG:
                        begin
                            if (pending_kind_reg == KIND_WRITE)
                            begin
                                shift_byte_next = held_value_reg;
                                bit_count_next  = 4'd0;
                                byte_index_next = BYTE_DATA;
                                phase_next      = PH_WB0;
                            end
                            else
                            begin
                                byte_index_next = BYTE_DATA;
                                phase_next      = PH_ST0;
                            end
                        end
                        BYTE_DATA:
                        begin
                            if (pending_kind_reg == KIND_WRITE)
                            begin
                                phase_next = PH_SP0;
                            end
                            else
                            begin
                                byte_index_next = BYTE_DEV_RD;
                                phase_next      = PH_RD0;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_SP0;
                        end
                    endcase
                end
            end
            PH_RD0:
            begin
                scl_next   = 1'b0;
                phase_next = PH_RD1;
            end
            PH_RD1:
            begin
                rel_next        = 1'b1;
                bit_count_next  = 4'd0;
                read_shift_next = 8'd0;
                phase_next      = PH_RB0;
            end
            PH_RB0:
            begin
                scl_next   = 1'b1;
                phase_next = PH_RB1;
            end
            PH_RB1:
            begin
                read_shift_next = {read_shift_reg[6:0], in_data_reg.sda_sample};
                scl_next        = 1'b0;
                bit_count_next  = bc_inc;
                phase_next      = (bc_inc >= BITS_PER_BYTE) ? PH_RN0 : PH_RB0;
            end
            PH_RN0:
            begin
                rel_next   = 1'b0;
                phase_next = PH_RN1;
            end
            PH_RN1:
            begin
                sda_next   = 1'b1;
                phase_next = PH_RN2;
            end
            PH_RN2:
            begin
                scl_next   = 1'b1;
                retry_next = 1'b0;
                phase_next = PH_SP0;
            end
            PH_SP0:
            begin
                scl_next   = 1'b0;
                phase_next = PH_SP1;
            end
            PH_SP1:
            begin
                sda_next   = 1'b0;
                phase_next = PH_SP2;
            end
            PH_SP2:
            begin
                scl_next   = 1'b1;
                phase_next = PH_SP3;
            end
            PH_SP3:
            begin
                sda_next = 1'b1;
                if (retry_reg)
                begin
                    retry_next      = 1'b0;
                    byte_index_next = BYTE_DEV_WR;
                    phase_next      = PH_ST0;
                end
                else
                begin
                    done_next = 1'b1;
                    if (pending_kind_reg == KIND_READ)
                    begin
                        last_read_next = read_shift_reg;
                    end
                    pending_kind_next = KIND_TICK;
                    phase_next        = PH_IDLE;
                end
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase

        out_data_next.scl_level    = scl_next;
        out_data_next.sda_level    = rel_next ? 1'b0 : sda_next;
        out_data_next.sda_released = rel_next;
        out_data_next.busy_res     = (phase_next != PH_IDLE);
        out_data_next.done_res     = done_next;
        out_data_next.read_value   = last_read_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dev_wr_addr_reg   <= 8'd0;
            dev_rd_addr_reg   <= 8'd0;
            in_vld_reg        <= 1'b0;
            in_data_reg       <= '0;
            out_vld_reg       <= 1'b0;
            out_data_reg      <= '0;
            phase_reg         <= PH_IDLE;
            bit_count_reg     <= 4'd0;
            shift_byte_reg    <= 8'd0;
            pending_kind_reg  <= KIND_TICK;
            held_register_reg <= 8'd0;
            held_value_reg    <= 8'd0;
            read_shift_reg    <= 8'd0;
            byte_index_reg    <= BYTE_DEV_WR;
            scl_reg           <= 1'b1;
            sda_reg           <= 1'b1;
            rel_reg           <= 1'b0;
            nack_reg          <= 1'b0;
            retry_reg         <= 1'b0;
            last_read_reg     <= 8'd0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (paddr[2] == REG_DEV_RD_ADDR)
                begin
                    dev_rd_addr_reg <= pwdata[7:0];
                end
                else
                begin
                    dev_wr_addr_reg <= pwdata[7:0];
                end
            end

            // input register
            if (request.valid && request.ready)
            begin
                in_vld_reg  <= 1'b1;
                in_data_reg <= request.data;
            end
            else if (move)
            begin
                in_vld_reg <= 1'b0;
            end

            // output register
            if (move)
            begin
                out_vld_reg  <= 1'b1;
                out_data_reg <= out_data_next;
            end
            else if (response.ready)
            begin
                out_vld_reg <= 1'b0;
            end

            if (move)
            begin
                phase_reg         <= phase_next;
                bit_count_reg     <= bit_count_next;
                shift_byte_reg    <= shift_byte_next;
                pending_kind_reg  <= pending_kind_next;
                held_register_reg <= held_register_next;
                held_value_reg    <= held_value_next;
                read_shift_reg    <= read_shift_next;
                byte_index_reg    <= byte_index_next;
                scl_reg           <= scl_next;
                sda_reg           <= sda_next;
                rel_reg           <= rel_next;
                nack_reg          <= nack_next;
                retry_reg         <= retry_next;
                last_read_reg     <= last_read_next;
            end
        end
    end

endmodule

// ===== sv/i2cmra_checker.sv =====
// ----------------------------------------------------------------------------
// i2cmra_checker
// port-level checks of the i2c register access master, bound to the top level
// ----------------------------------------------------------------------------
module i2cmra_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         res_valid,
    input logic                         res_ready,
    input i2cmra_pkg::out_item_t        res_data,
    input logic                         pready
);
    import i2cmra_pkg::*;

    // stalled response holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("response changed while stalled");

    // a finished transfer leaves the bus idle and the master not busy
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.done_res |->
            !res_data.busy_res && res_data.scl_level && res_data.sda_level
            && !res_data.sda_released)
        else $error("done without idle bus");

    // released sda reads as low drive
    a_release_low: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.sda_released |-> !res_data.sda_level)
        else $error("sda driven while released");

    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind i2c_master_register_access_unit i2cmra_checker u_i2cmra_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (response.valid),
    .res_ready (response.ready),
    .res_data  (response.data),
    .pready    (pready)
);

// ===== bench/i2c_master_register_access_unit_tb.sv =====
// ----------------------------------------------------------------------------
// i2c_master_register_access_unit_tb
// drives pin-update ticks into the i2c register access master over the
// request channel and checks every pin step on the response channel against
// a tick-by-tick sequencer model kept in the bench; covers writes, reads,
// nack restarts, requests while busy and device address changes over apb
// ----------------------------------------------------------------------------
module i2c_master_register_access_unit_tb;
    import i2cmra_pkg::*;

    localparam int RANDOM_ITEMS = 100;
    localparam int CFG_SPACING  = 300;
    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 4;

    localparam logic [1:0] KIND_SPARE = 2'd3;

    localparam int FILL_ZERO   = 0;
    localparam int FILL_ONE    = 1;
    localparam int FILL_RANDOM = 2;

    // position in the byte sequence of one transaction
    localparam logic [1:0] POS_DEV_ADDR = 2'd0;
    localparam logic [1:0] POS_REG      = 2'd1;
    localparam logic [1:0] POS_THIRD    = 2'd2;
    localparam logic [1:0] POS_READ     = 2'd3;

    typedef enum logic [5:0] {
        SEQ_IDLE, SEQ_ST0, SEQ_ST1, SEQ_ST2,
        SEQ_WB0, SEQ_WB1, SEQ_WB2,
        SEQ_AK0, SEQ_AK1, SEQ_AK2, SEQ_AK3, SEQ_AK4,
        SEQ_RD0, SEQ_RD1, SEQ_RB0, SEQ_RB1,
        SEQ_RN0, SEQ_RN1, SEQ_RN2,
        SEQ_SP0, SEQ_SP1, SEQ_SP2, SEQ_SP3
    } seq_phase_t;

    typedef enum int {RDY_ALWAYS, RDY_MOSTLY, RDY_SPARSE, RDY_PERIODIC} ready_style_t;

    logic              clk;
    logic              rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    i2cmra_in_if  req_if ();
    i2cmra_out_if rsp_if ();

    i2c_master_register_access_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (req_if),
        .response (rsp_if),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // sequencer model state
    seq_phase_t m_phase;
    logic [3:0] m_bits;
    logic [7:0] m_shift;
    logic [1:0] m_kind;
    logic [7:0] m_reg;
    logic [7:0] m_val;
    logic [7:0] m_rshift;
    logic [1:0] m_byte;
    logic       m_scl;
    logic       m_sda;
    logic       m_rel;
    logic       m_nack;
    logic       m_retry;
    logic [7:0] m_last;
    logic [7:0] cfg_wr_addr;
    logic [7:0] cfg_rd_addr;

    out_item_t pin_queue[$];
    int        error_count;
    int        items_sent;
    int        burst_left;
    int        quiet_cycles;
    int        ready_span;
    ready_style_t ready_style;

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic void load_shift(input logic [7:0] value, input logic [1:0] pos);
        m_shift = value;
        m_bits  = 4'd0;
        m_byte  = pos;
        m_phase = SEQ_WB0;
    endfunction

    function automatic logic advance_sequencer(input logic sda_in);
        logic done;
        done = 1'b0;
        case (m_phase)
            SEQ_ST0:
            begin
                m_sda = 1'b1;
                m_phase = SEQ_ST1;
            end
            SEQ_ST1:
            begin
                m_scl = 1'b1;
                m_phase = SEQ_ST2;
            end
            SEQ_ST2:
            begin
                m_sda = 1'b0;
                load_shift((m_byte == POS_DEV_ADDR) ? cfg_wr_addr : cfg_rd_addr, m_byte);
            end
            SEQ_WB0:
            begin
                m_scl = 1'b0;
                m_phase = SEQ_WB1;
            end
            SEQ_WB1:
            begin
                m_sda = m_shift[7];
                m_phase = SEQ_WB2;
            end
            SEQ_WB2:
            begin
                m_scl = 1'b1;
                m_shift = {m_shift[6:0], 1'b0};
                m_bits = m_bits + 4'd1;
                m_phase = (m_bits >= BITS_PER_BYTE) ? SEQ_AK0 : SEQ_WB0;
            end
            SEQ_AK0:
            begin
                m_scl = 1'b0;
                m_phase = SEQ_AK1;
            end
            SEQ_AK1:
            begin
                m_rel = 1'b1;
                m_phase = SEQ_AK2;
            end
            SEQ_AK2:
            begin
                m_scl = 1'b1;
                m_phase = SEQ_AK3;
            end
            SEQ_AK3:
            begin
                m_nack = sda_in;
                m_scl = 1'b0;
                m_phase = SEQ_AK4;
            end
            SEQ_AK4:
            begin
                m_rel = 1'b0;
                if (m_nack)
                begin
                    m_retry = 1'b1;
                    m_phase = SEQ_SP0;
                end
                else
                begin
                    case (m_byte)
                        POS_DEV_ADDR: load_shift(m_reg, POS_REG);
                        POS_REG:
                        begin
                            if (m_kind == KIND_WRITE)
                                load_shift(m_val, POS_THIRD);
                            else
                            begin
                                // repeated start for the read address
                                m_byte = POS_THIRD;
                                m_phase = SEQ_ST0;
                            end
                        end
                        POS_THIRD:
                        begin
                            if (m_kind == KIND_WRITE)
                                m_phase = SEQ_SP0;
                            else
                            begin
                                m_byte = POS_READ;
                                m_phase = SEQ_RD0;
                            end
                        end
                        default: m_phase = SEQ_SP0;
                    endcase
                end
            end
            SEQ_RD0:
            begin
                m_scl = 1'b0;
                m_phase = SEQ_RD1;
            end
            SEQ_RD1:
            begin
                m_rel = 1'b1;
                m_bits = 4'd0;
                m_rshift = 8'd0;
                m_phase = SEQ_RB0;
            end
            SEQ_RB0:
            begin
                m_scl = 1'b1;
                m_phase = SEQ_RB1;
            end
            SEQ_RB1:
            begin
                m_rshift = {m_rshift[6:0], sda_in};
                m_scl = 1'b0;
                m_bits = m_bits + 4'd1;
                m_phase = (m_bits >= BITS_PER_BYTE) ? SEQ_RN0 : SEQ_RB0;
            end
            SEQ_RN0:
            begin
                m_rel = 1'b0;
                m_phase = SEQ_RN1;
            end
            SEQ_RN1:
            begin
                m_sda = 1'b1;
                m_phase = SEQ_RN2;
            end
            SEQ_RN2:
            begin
                m_scl = 1'b1;
                m_retry = 1'b0;
                m_phase = SEQ_SP0;
            end
            SEQ_SP0:
            begin
                m_scl = 1'b0;
                m_phase = SEQ_SP1;
            end
            SEQ_SP1:
            begin
                m_sda = 1'b0;
                m_phase = SEQ_SP2;
            end
            SEQ_SP2:
            begin
                m_scl = 1'b1;
                m_phase = SEQ_SP3;
            end
            SEQ_SP3:
            begin
                m_sda = 1'b1;
                if (m_retry)
                begin
                    m_retry = 1'b0;
                    m_byte = POS_DEV_ADDR;
                    m_phase = SEQ_ST0;
                end
                else
                begin
                    done = 1'b1;
                    if (m_kind == KIND_READ)
                        m_last = m_rshift;
                    m_kind = KIND_TICK;
                    m_phase = SEQ_IDLE;
                end
            end
            default: m_phase = SEQ_IDLE;
        endcase
        return done;
    endfunction

    function automatic out_item_t predict_pins(input in_item_t it);
        out_item_t o;
        logic      done;
        done = 1'b0;
        if (m_phase == SEQ_IDLE)
        begin
            if (it.kind == KIND_WRITE || it.kind == KIND_READ)
            begin
                m_kind = it.kind;
                m_reg = it.register_address;
                m_val = it.write_value;
                m_byte = POS_DEV_ADDR;
                m_bits = 4'd0;
                m_retry = 1'b0;
                m_nack = 1'b0;
                m_phase = SEQ_ST0;
                done = advance_sequencer(it.sda_sample);
            end
        end
        else
            done = advance_sequencer(it.sda_sample);
        o.scl_level = m_scl;
        o.sda_level = m_rel ? 1'b0 : m_sda;
        o.sda_released = m_rel;
        o.busy_res = (m_phase != SEQ_IDLE);
        o.done_res = done;
        o.read_value = m_last;
        return o;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
        error_count++;
    endtask

    always @(posedge clk)
    begin : pin_check
        out_item_t want;
        out_item_t got;
        if (rst_n)
        begin
            if (req_if.valid && req_if.ready)
                pin_queue.push_back(predict_pins(req_if.data));
            if (rsp_if.valid && rsp_if.ready)
            begin
                got = rsp_if.data;
                if (pin_queue.size() == 0)
                    report_mismatch("transfer with nothing pending", got.read_value, 8'd0);
                else
                begin
                    want = pin_queue.pop_front();
                    if (got.scl_level !== want.scl_level)
                        report_mismatch("scl_level", 8'(got.scl_level),
                                        8'(want.scl_level));
                    if (got.sda_level !== want.sda_level)
                        report_mismatch("sda_level", 8'(got.sda_level),
                                        8'(want.sda_level));
                    if (got.sda_released !== want.sda_released)
                        report_mismatch("sda_released", 8'(got.sda_released),
                                        8'(want.sda_released));
                    if (got.busy_res !== want.busy_res)
                        report_mismatch("busy_res", 8'(got.busy_res), 8'(want.busy_res));
                    if (got.done_res !== want.done_res)
                        report_mismatch("done_res", 8'(got.done_res), 8'(want.done_res));
                    if (got.read_value !== want.read_value)
                        report_mismatch("read_value", got.read_value, want.read_value);
                end
            end
        end
    end

    always @(negedge clk)
    begin
        if (ready_span == 0)
        begin
            ready_style = ready_style_t'($urandom_range(0, 3));
            ready_span = $urandom_range(8, 64);
        end
        ready_span--;
        case (ready_style)
            RDY_ALWAYS: rsp_if.ready <= 1'b1;
            RDY_MOSTLY: rsp_if.ready <= ($urandom_range(0, 3) != 0);
            RDY_SPARSE: rsp_if.ready <= ($urandom_range(0, 2) == 0);
            default:    rsp_if.ready <= (ready_span[2:0] != 3'd0);
        endcase
    end

    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || psel)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // called and returns at a falling edge
    task automatic send_tick(input in_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            if ($urandom_range(0, 3) == 0)
            begin
                gap = 0;
                burst_left = $urandom_range(40, 120);
            end
            else
            begin
                gap = $urandom_range(0, 6);
                if ($urandom_range(0, 15) == 0)
                    gap = $urandom_range(7, 20);
                burst_left = $urandom_range(1, 12);
            end
            if (gap > 0)
            begin
                req_if.valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        req_if.valid <= 1'b1;
        req_if.data <= it;
        do
            @(posedge clk);
        while (!(req_if.valid && req_if.ready));
        @(negedge clk);
        burst_left--;
        items_sent++;
    endtask

    // plain ticks with sda low acknowledge every byte, so any transaction ends
    task automatic settle_idle();
        in_item_t it;
        it = '0;
        while (m_phase != SEQ_IDLE)
            send_tick(it);
        req_if.valid <= 1'b0;
        burst_left = 0;
        while (pin_queue.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] value);
        logic [APB_DW-1:0] got;
        settle_idle();
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= APB_DW'(value);
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if (idx == REG_DEV_WR_ADDR)
            cfg_wr_addr = value;
        else
            cfg_rd_addr = value;
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        got = prdata;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        if (got !== APB_DW'(value))
            report_mismatch("register readback", got[7:0], value);
    endtask

    task automatic configure(input logic [7:0] wr_addr, input logic [7:0] rd_addr);
        write_reg(REG_DEV_WR_ADDR, wr_addr);
        write_reg(REG_DEV_RD_ADDR, rd_addr);
    endtask

    // nack_mask forces the answer of the first eight acknowledge slots
    task automatic run_transaction(input logic [1:0] kind, input logic [7:0] reg_num,
                                   input logic [7:0] data_byte, input int read_fill,
                                   input logic [7:0] nack_mask, input int nack_pct,
                                   input bit noisy);
        in_item_t it;
        int       ack_no;
        ack_no = 0;
        it.kind = kind;
        it.register_address = reg_num;
        it.write_value = data_byte;
        it.sda_sample = 1'($urandom_range(0, 1));
        send_tick(it);
        while (m_phase != SEQ_IDLE)
        begin
            if (noisy && $urandom_range(0, 3) == 0)
                it.kind = 2'($urandom_range(0, 3));
            else
                it.kind = KIND_TICK;
            it.register_address = 8'($urandom);
            it.write_value = 8'($urandom);
            if (m_phase == SEQ_AK3)
            begin
                if (ack_no < 8)
                    it.sda_sample = nack_mask[ack_no];
                else
                    it.sda_sample = ($urandom_range(0, 99) < nack_pct);
                ack_no++;
            end
            else if (m_phase == SEQ_RB1 && read_fill != FILL_RANDOM)
                it.sda_sample = read_fill[0];
            else
                it.sda_sample = 1'($urandom_range(0, 1));
            send_tick(it);
        end
    endtask

    task automatic test_idle_ticks();
        run_transaction(KIND_TICK, 8'h00, 8'h00, FILL_RANDOM, 8'h00, 0, 1'b0);
        run_transaction(KIND_TICK, 8'hFF, 8'hFF, FILL_RANDOM, 8'h00, 0, 1'b0);
        run_transaction(KIND_SPARE, 8'h00, 8'hFF, FILL_RANDOM, 8'h00, 0, 1'b0);
        run_transaction(KIND_SPARE, 8'hFF, 8'h00, FILL_RANDOM, 8'h00, 0, 1'b0);
    endtask

    task automatic test_register_write();
        // first write runs with the reset device address
        run_transaction(KIND_WRITE, 8'hFF, 8'h00, FILL_RANDOM, 8'h00, 0, 1'b0);
        configure(8'hFF, 8'h00);
        run_transaction(KIND_WRITE, 8'h00, 8'hFF, FILL_RANDOM, 8'h00, 0, 1'b0);
    endtask

    task automatic test_register_read();
        configure(8'hA4, 8'hFF);
        run_transaction(KIND_READ, 8'h00, 8'h00, FILL_ONE, 8'h00, 0, 1'b0);
        run_transaction(KIND_READ, 8'hFF, 8'hFF, FILL_ZERO, 8'h00, 0, 1'b0);
        run_transaction(KIND_READ, 8'h5A, 8'hA5, FILL_RANDOM, 8'h00, 0, 1'b0);
        // write after read keeps the last read byte
        run_transaction(KIND_WRITE, 8'h3C, 8'hC3, FILL_RANDOM, 8'h00, 0, 1'b0);
    endtask

    task automatic test_nack_retry();
        configure(8'h00, 8'hA1);
        run_transaction(KIND_WRITE, 8'h12, 8'h34, FILL_RANDOM, 8'b0000_0001, 0, 1'b0);
        run_transaction(KIND_WRITE, 8'h56, 8'h78, FILL_RANDOM, 8'b0000_0010, 0, 1'b0);
        run_transaction(KIND_WRITE, 8'h9A, 8'hBC, FILL_RANDOM, 8'b0000_0100, 0, 1'b0);
        run_transaction(KIND_READ, 8'hDE, 8'h00, FILL_ONE, 8'b0010_0100, 0, 1'b0);
        run_transaction(KIND_READ, 8'h81, 8'h00, FILL_RANDOM, 8'b0001_1111, 0, 1'b0);
    endtask

    task automatic test_busy_requests();
        run_transaction(KIND_WRITE, 8'hC0, 8'h0C, FILL_RANDOM, 8'h00, 0, 1'b1);
        run_transaction(KIND_READ, 8'h03, 8'h30, FILL_RANDOM, 8'h00, 0, 1'b1);
    endtask

    task automatic test_random_traffic();
        int stop_at;
        int next_cfg;
        stop_at = items_sent + RANDOM_ITEMS;
        next_cfg = items_sent;
        while (items_sent < stop_at)
        begin
            if (items_sent >= next_cfg)
            begin
                case ($urandom_range(0, 3))
                    0: configure(8'h00, 8'h00);
                    1: configure(8'hFF, 8'hFF);
                    default: configure(8'($urandom), 8'($urandom));
                endcase
                next_cfg = items_sent + CFG_SPACING;
            end
            if ($urandom_range(0, 7) == 0)
                run_transaction($urandom_range(0, 1) ? KIND_SPARE : KIND_TICK,
                                8'($urandom), 8'($urandom), FILL_RANDOM, 8'h00, 0, 1'b0);
            else
                run_transaction($urandom_range(0, 1) ? KIND_WRITE : KIND_READ,
                                8'($urandom), 8'($urandom), $urandom_range(0, 2),
                                8'($urandom & $urandom & $urandom), 8,
                                ($urandom_range(0, 2) == 0));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.data = '0;
        rsp_if.ready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        error_count = 0;
        items_sent = 0;
        burst_left = 0;
        quiet_cycles = 0;
        ready_span = 0;
        ready_style = RDY_ALWAYS;
        m_phase = SEQ_IDLE;
        m_bits = 4'd0;
        m_shift = 8'd0;
        m_kind = KIND_TICK;
        m_reg = 8'd0;
        m_val = 8'd0;
        m_rshift = 8'd0;
        m_byte = POS_DEV_ADDR;
        m_scl = 1'b1;
        m_sda = 1'b1;
        m_rel = 1'b0;
        m_nack = 1'b0;
        m_retry = 1'b0;
        m_last = 8'd0;
        cfg_wr_addr = 8'd0;
        cfg_rd_addr = 8'd0;
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_idle_ticks();
        test_register_write();
        test_register_read();
        test_nack_retry();
        test_busy_requests();
        test_random_traffic();
        settle_idle();
        repeat (8) @(negedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
